// ----- design/hed_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types, constants and the entity table of the HTML entity decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

  // Size of the downstream text buffer; one byte is kept for the terminator.
  localparam int unsigned OUT_BUFFER_BYTES = 2048;
  localparam int unsigned CHAR_CAP         = OUT_BUFFER_BYTES - 1;

  localparam int unsigned CNT_W         = 11;
  localparam logic [CNT_W-1:0] MAX_OUT_RESET = 11'd2047;

  localparam int unsigned PEND_DEPTH  = 5;
  localparam int unsigned CMD_SLOTS   = PEND_DEPTH + 1;
  localparam int unsigned NUM_ENT     = 5;
  localparam int unsigned ENT_MAX_LEN = 6;
  localparam int unsigned CMD_DEPTH   = 4;

  localparam logic [7:0] CHAR_AMP = 8'h26;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // Entity spellings, lengths and replacement bytes.
  localparam logic [7:0] ENT_TEXT [NUM_ENT][ENT_MAX_LEN] = '{
    '{"&", "g", "t", ";", 8'h00, 8'h00},
    '{"&", "l", "t", ";", 8'h00, 8'h00},
    '{"&", "q", "u", "o", "t", ";"},
    '{"&", "n", "b", "s", "p", ";"},
    '{"&", "a", "m", "p", ";", 8'h00}
  };
  localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd4, 3'd4, 3'd6, 3'd6, 3'd5};
  localparam logic [7:0] ENT_VAL [NUM_ENT] = '{">", "<", 8'h22, " ", "&"};

  typedef struct packed {
    logic [7:0] char_in;
    logic       text_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       run_last;
    logic       text_end;
  } out_item_t;

  // One classified input: the bytes that survive the limit, then an
  // optional terminator.
  typedef struct packed {
    logic [CMD_SLOTS-1:0][7:0] chars;
    logic [2:0]                cnt;
    logic                      term;
  } cmd_t;

endpackage
`default_nettype wire

// ----- design/hed_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hed_front
// Match entities, track the partial entity and the per-text character count,
// and turn each accepted request into at most one command for the back end.
// ----------------------------------------------------------------------------
module hed_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire hed_pkg::in_item_t           in_item,
  input  wire logic [hed_pkg::CNT_W-1:0]   max_out_chars,
  output logic                             cmd_push,
  output hed_pkg::cmd_t                    cmd
);

  logic [7:0]               pend_r [hed_pkg::PEND_DEPTH];
  logic [2:0]               pcount_r, pcount_nxt;
  logic [hed_pkg::CNT_W-1:0] emitted_r, emitted_nxt;

  logic [7:0]               c;
  logic                     is_zero, is_amp, term;
  logic [hed_pkg::NUM_ENT-1:0] full_hit, pre_hit;
  logic                     full_any, prefix_any;
  logic [7:0]               full_val;
  logic                     incl_old, has_x, start_amp, append;
  logic [7:0]               x;
  logic [2:0]               count_a, n_raw, keep;
  logic [hed_pkg::CNT_W-1:0] limit, room;
  logic [2:0]               len;

  always_comb begin
    c       = in_item.char_in;
    is_zero = (c == hed_pkg::CHAR_NUL);
    is_amp  = (c == hed_pkg::CHAR_AMP);
    term    = is_zero || in_item.text_last;
    len     = pcount_r + 3'd1;

    // Compare buffer plus new byte against every entity in parallel.
    for (int e = 0; e < hed_pkg::NUM_ENT; e++) begin
      logic ok;
      ok = (pcount_r < 3'(hed_pkg::ENT_MAX_LEN));
      for (int k = 0; k < hed_pkg::PEND_DEPTH; k++) begin
        if (3'(k) < pcount_r && pend_r[k] != hed_pkg::ENT_TEXT[e][k]) begin
          ok = 1'b0;
        end
      end
      if (ok && c != hed_pkg::ENT_TEXT[e][pcount_r]) begin
        ok = 1'b0;
      end
      full_hit[e] = ok && (len == hed_pkg::ENT_LEN[e]);
      pre_hit[e]  = ok && (len <  hed_pkg::ENT_LEN[e]);
    end
    full_any   = |full_hit;
    prefix_any = |pre_hit;
    full_val   = hed_pkg::CHAR_NUL;
    for (int e = hed_pkg::NUM_ENT - 1; e >= 0; e--) begin
      if (full_hit[e]) begin
        full_val = hed_pkg::ENT_VAL[e];
      end
    end

    // Every result list is a run of the old buffer followed by at most one byte.
    incl_old   = 1'b0;
    has_x      = 1'b0;
    x          = c;
    start_amp  = 1'b0;
    append     = 1'b0;
    pcount_nxt = pcount_r;
    if (is_zero) begin
      incl_old   = 1'b1;
      pcount_nxt = '0;
    end else if (pcount_r == '0) begin
      if (is_amp) begin
        start_amp  = 1'b1;
        has_x      = term;
        pcount_nxt = term ? 3'd0 : 3'd1;
      end else begin
        has_x = 1'b1;
      end
    end else if (full_any) begin
      has_x      = 1'b1;
      x          = full_val;
      pcount_nxt = '0;
    end else if (prefix_any && pcount_r < 3'(hed_pkg::PEND_DEPTH)) begin
      append     = 1'b1;
      incl_old   = term;
      has_x      = term;
      pcount_nxt = term ? 3'd0 : len;
    end else begin
      incl_old = 1'b1;
      if (is_amp) begin
        start_amp  = 1'b1;
        has_x      = term;
        pcount_nxt = term ? 3'd0 : 3'd1;
      end else begin
        has_x      = 1'b1;
        pcount_nxt = '0;
      end
    end

    count_a = incl_old ? pcount_r : 3'd0;
    n_raw   = count_a + {2'b00, has_x};

    // Drop whatever runs past the character limit.
    limit = ({21'b0, max_out_chars} < hed_pkg::CHAR_CAP) ? max_out_chars
                                                         : hed_pkg::CNT_W'(hed_pkg::CHAR_CAP);
    room  = (emitted_r >= limit) ? '0 : (limit - emitted_r);
    keep  = (room < {8'b0, n_raw}) ? room[2:0] : n_raw;

    for (int i = 0; i < hed_pkg::PEND_DEPTH; i++) begin
      cmd.chars[i] = (3'(i) < count_a) ? pend_r[i] : x;
    end
    cmd.chars[hed_pkg::CMD_SLOTS-1] = x;
    cmd.cnt  = keep;
    cmd.term = term;
    cmd_push = accept && (term || keep != '0);

    emitted_nxt = term ? '0 : (emitted_r + {8'b0, keep});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r  <= '0;
      emitted_r <= '0;
    end else if (accept) begin
      pcount_r  <= pcount_nxt;
      emitted_r <= emitted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && start_amp) begin
      pend_r[0] <= hed_pkg::CHAR_AMP;
    end
    if (accept && append) begin
      pend_r[pcount_r] <= c;
    end
  end

endmodule
`default_nettype wire

// ----- design/hed_cmd_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hed_cmd_fifo
// Short command queue between the classifier and the serializer.
// ----------------------------------------------------------------------------
module hed_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire hed_pkg::cmd_t  wr_cmd,
  output logic                full,
  input  wire logic           rd_en,
  output hed_pkg::cmd_t       rd_cmd,
  output logic                empty
);

  localparam int unsigned PTR_W = $clog2(hed_pkg::CMD_DEPTH);
  localparam int unsigned CNT_W = $clog2(hed_pkg::CMD_DEPTH + 1);

  hed_pkg::cmd_t    mem_r [hed_pkg::CMD_DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  always_comb begin
    full   = (count_r == CNT_W'(hed_pkg::CMD_DEPTH));
    empty  = (count_r == '0);
    do_wr  = wr_en && !full;
    do_rd  = rd_en && !empty;
    rd_cmd = mem_r[rptr_r];
    count_nxt = count_r + CNT_W'(do_wr) - CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_wr) begin
        wptr_r <= (wptr_r == PTR_W'(hed_pkg::CMD_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == PTR_W'(hed_pkg::CMD_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- design/hed_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hed_back
// Serialize the head command into result items, one per cycle while the
// result side pops, through a single output register.
// ----------------------------------------------------------------------------
module hed_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hed_pkg::cmd_t      head,
  input  wire logic               head_valid,
  output logic                    head_pop,
  output hed_pkg::out_item_t      out_item,
  output logic                    empty,
  input  wire logic               pop
);

  logic [2:0]         idx_r, idx_nxt;
  hed_pkg::out_item_t out_r, out_nxt;
  logic               valid_r, valid_nxt;
  logic               load, last_elem;

  always_comb begin
    load = head_valid && (!valid_r || pop);
    if (idx_r < head.cnt) begin
      out_nxt.char_out = head.chars[idx_r];
      out_nxt.text_end = 1'b0;
      last_elem        = (idx_r == head.cnt - 3'd1) && !head.term;
    end else begin
      out_nxt.char_out = hed_pkg::CHAR_NUL;
      out_nxt.text_end = 1'b1;
      last_elem        = 1'b1;
    end
    out_nxt.run_last = last_elem;
    head_pop  = load && last_elem;
    idx_nxt   = load ? (last_elem ? 3'd0 : idx_r + 3'd1) : idx_r;
    valid_nxt = load || (valid_r && !pop);
    empty     = !valid_r;
    out_item  = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/html_entity_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// html_entity_decoder
// Byte-stream HTML entity decoder: &gt; &lt; &quot; &nbsp; &amp; become
// > < " space &, with a per-text output limit and a closing zero byte.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  input    | push / full          | in_item  (char_in, text_last)
//  result   | empty / pop          | out_item (char_out, run_last, text_end)
//  config   | cfg_we               | cfg_wdata (max_out_chars)
//
//  One request is taken every cycle while the four-entry command queue has
//  room; each request yields zero to seven results, drained at one per cycle
//  by the serializer while results are popped, so sustained input rate
//  follows the result count. A result passes through the command queue
//  and the output register before it shows on the output.
//  Reset (rst_n low at a clock edge) empties the queue and output register,
//  clears the partial entity and character count, and sets the limit to 2047.
//  A stalled result holds on out_item until popped; full rises only when the
//  queue fills and takes no request until the serializer retires a command.
// ----------------------------------------------------------------------------
module html_entity_decoder (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  output logic                            full,
  input  wire hed_pkg::in_item_t          in_item,
  output logic                            empty,
  input  wire logic                       pop,
  output hed_pkg::out_item_t              out_item,
  input  wire logic                       cfg_we,
  input  wire logic [hed_pkg::CNT_W-1:0]  cfg_wdata
);

  logic [hed_pkg::CNT_W-1:0] max_out_chars_r;
  logic                      accept;
  logic                      cmd_push;
  hed_pkg::cmd_t             cmd;
  hed_pkg::cmd_t             head;
  logic                      q_empty;
  logic                      head_pop;

  // Hold the output limit; user writes it only while idle, not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_out_chars_r <= hed_pkg::MAX_OUT_RESET;
    end else if (cfg_we) begin
      max_out_chars_r <= cfg_wdata;
    end
  end

  // Take a request whenever the queue has room, even if it yields nothing.
  assign accept = push && !full;

  // Classify: match entities, buffer partial ones, apply the limit.
  hed_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_item       (in_item),
    .max_out_chars (max_out_chars_r),
    .cmd_push      (cmd_push),
    .cmd           (cmd)
  );

  // Decouple classification from serialization.
  hed_cmd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_push),
    .wr_cmd (cmd),
    .full   (full),
    .rd_en  (head_pop),
    .rd_cmd (head),
    .empty  (q_empty)
  );

  // Advance through each command one result at a time.
  hed_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!q_empty),
    .head_pop   (head_pop),
    .out_item   (out_item),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
`default_nettype wire

// ----- design/hed_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hed_checker
// Port-level checks of the HTML entity decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hed_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic                       full,
  input  wire logic                       empty,
  input  wire logic                       pop,
  input  wire hed_pkg::out_item_t         out_item
);

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("result changed while stalled");

  // The terminator is a zero byte and closes its request.
  a_term: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.text_end) |->
      (out_item.run_last && out_item.char_out == hed_pkg::CHAR_NUL))
    else $error("malformed terminator");

  // Decoded bytes are never zero; a zero byte is always the terminator.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.char_out == hed_pkg::CHAR_NUL) |-> out_item.text_end)
    else $error("zero byte without text end");

  // Reset leaves no result waiting.
  a_rst: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result present after reset");

  // The queue fills only through requests.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full) |-> $past(push))
    else $error("full rose without a request");

endmodule

bind html_entity_decoder hed_checker u_hed_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .push      (push),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_item  (out_item)
);
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the HTML entity decoder against a byte-level decode predictor.
// A short scripted text comes first, then random texts under eight
// character-limit settings, with idling on both queues and one long output
// hold-off that fills the decoder and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_HALF_NS   = 10;
  localparam int RESET_CYCLES  = 2;
  localparam int N_PHASES      = 8;
  localparam int PHASE_ITEMS   = 42;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_CYCLES   = 80;
  // Results pass through the command queue and the output register; a
  // request that makes no result puts no command in the queue.
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_LOGGED    = 40;
  localparam longint LIMIT_NS  = 64'd10_000_000;
  localparam int LIMIT_MAX     = (1 << hed_pkg::CNT_W) - 1;

  // Our own spelling of the five entities, right-justified in 48 bits.
  localparam logic [47:0] ENT_SPELL [5] = '{"&gt;", "&lt;", "&quot;", "&nbsp;", "&amp;"};
  localparam int          ENT_SIZE  [5] = '{4, 4, 6, 6, 5};
  localparam logic [7:0]  ENT_CHAR  [5] = '{8'h3E, 8'h3C, 8'h22, 8'h20, 8'h26};

  typedef enum logic [1:0] {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

  // One scripted request; res is used only where typed is set.
  typedef struct packed {
    logic [7:0]         ch;
    logic               last;
    logic               typed;
    hed_pkg::out_item_t res;
  } script_row_t;

  localparam logic               TYPED  = 1'b1;
  localparam logic               PRED   = 1'b0;
  localparam hed_pkg::out_item_t NO_RES = '0;
  localparam hed_pkg::out_item_t TERM   = {hed_pkg::CHAR_NUL, 1'b1, 1'b1};
  localparam int                 SCRIPT_LEN = 25;

  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // plain bytes straight after reset, including the highest and lowest nonzero byte
    '{"A",   1'b0, TYPED, {8'h41, 1'b1, 1'b0}},
    '{8'hFF, 1'b0, TYPED, {8'hFF, 1'b1, 1'b0}},
    '{8'h01, 1'b0, TYPED, {8'h01, 1'b1, 1'b0}},
    // complete entities
    '{"&", 1'b0, PRED, NO_RES}, '{"g", 1'b0, PRED, NO_RES},
    '{"t", 1'b0, PRED, NO_RES}, '{";", 1'b0, PRED, NO_RES},
    '{"&", 1'b0, PRED, NO_RES}, '{"a", 1'b0, PRED, NO_RES},
    '{"m", 1'b0, PRED, NO_RES}, '{"p", 1'b0, PRED, NO_RES},
    '{";", 1'b0, PRED, NO_RES},
    // broken match: buffered bytes go out unchanged
    '{"&", 1'b0, PRED, NO_RES}, '{"q", 1'b0, PRED, NO_RES},
    '{"x", 1'b0, PRED, NO_RES},
    // a second ampersand restarts the match
    '{"&", 1'b0, PRED, NO_RES}, '{"&", 1'b0, PRED, NO_RES},
    '{"l", 1'b0, PRED, NO_RES}, '{"t", 1'b0, PRED, NO_RES},
    '{";", 1'b0, PRED, NO_RES},
    // partial entity closed by the last flag on a nonzero byte
    '{"&", 1'b0, PRED, NO_RES}, '{"n", 1'b0, PRED, NO_RES},
    '{"b", 1'b1, PRED, NO_RES},
    // zero byte with and without the last flag, nothing pending
    '{hed_pkg::CHAR_NUL, 1'b1, TYPED, TERM},
    '{hed_pkg::CHAR_NUL, 1'b0, TYPED, TERM}
  };

  // --------------------------------------------------------------------------
  // DUT signals, inputs all known from time zero
  // --------------------------------------------------------------------------
  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      push      = 1'b0;
  logic                      full;
  hed_pkg::in_item_t         in_item   = '0;
  logic                      empty;
  logic                      pop       = 1'b0;
  hed_pkg::out_item_t        out_item;
  logic                      cfg_we    = 1'b0;
  logic [hed_pkg::CNT_W-1:0] cfg_wdata = '0;

  // Stimulus control shared between the request and result sides.
  idle_mode_t idle_mode  = IDLE_NONE;
  int         hold_token = 0;
  int         err_count  = 0;
  int         phase_sent = 0;

  // Decode predictor state and the store of decoded bytes still to arrive.
  int                 lim_reg = LIMIT_MAX;
  logic [7:0]         held_bytes [hed_pkg::PEND_DEPTH];
  int                 held_cnt = 0;
  int                 char_cnt = 0;
  hed_pkg::out_item_t step_results [$];
  hed_pkg::out_item_t exp_results  [$];

  html_entity_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  // Hard stop in case the decoder hangs or drops results.
  initial begin
    #(LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Decode predictor
  // --------------------------------------------------------------------------
  function automatic logic [7:0] spell_at(int e, int k);
    return ENT_SPELL[e][(ENT_SIZE[e] - 1 - k) * 8 +: 8];
  endfunction

  // Emit one decoded byte unless this text has hit its character limit.
  function automatic void queue_char(logic [7:0] c);
    hed_pkg::out_item_t r;
    int lim;
    lim = (lim_reg < int'(hed_pkg::CHAR_CAP)) ? lim_reg : int'(hed_pkg::CHAR_CAP);
    if (char_cnt >= lim) return;
    r.char_out = c;
    r.run_last = 1'b0;
    r.text_end = 1'b0;
    step_results.push_back(r);
    char_cnt++;
  endfunction

  function automatic void flush_held();
    for (int k = 0; k < held_cnt; k++) queue_char(held_bytes[k]);
    held_cnt = 0;
  endfunction

  function automatic void decode_byte(logic [7:0] c);
    logic [7:0] cand [hed_pkg::PEND_DEPTH + 1];
    int n;
    bit part;
    bit hit;
    if (held_cnt == 0) begin
      if (c == hed_pkg::CHAR_AMP) begin
        held_bytes[0] = c;
        held_cnt = 1;
      end else begin
        queue_char(c);
      end
      return;
    end
    for (int k = 0; k < held_cnt; k++) cand[k] = held_bytes[k];
    cand[held_cnt] = c;
    n = held_cnt + 1;
    part = 1'b0;
    for (int e = 0; e < 5; e++) begin
      if (n <= ENT_SIZE[e]) begin
        hit = 1'b1;
        for (int k = 0; k < n; k++) if (cand[k] != spell_at(e, k)) hit = 1'b0;
        if (hit) begin
          // complete entity: replace the whole buffer with one byte
          if (n == ENT_SIZE[e]) begin
            held_cnt = 0;
            queue_char(ENT_CHAR[e]);
            return;
          end
          part = 1'b1;
        end
      end
    end
    // still a prefix of some entity: keep buffering
    if (part && held_cnt < int'(hed_pkg::PEND_DEPTH)) begin
      held_bytes[held_cnt] = c;
      held_cnt++;
      return;
    end
    // match broken: release the buffer as is, then treat c afresh
    flush_held();
    if (c == hed_pkg::CHAR_AMP) begin
      held_bytes[0] = c;
      held_cnt = 1;
    end else begin
      queue_char(c);
    end
  endfunction

  // Work out every result one request causes, into step_results.
  function automatic void predict_request(logic [7:0] ch, logic last);
    hed_pkg::out_item_t tail;
    step_results.delete();
    if (ch != hed_pkg::CHAR_NUL) decode_byte(ch);
    if (ch == hed_pkg::CHAR_NUL || last) begin
      flush_held();
      tail.char_out = hed_pkg::CHAR_NUL;
      tail.run_last = 1'b0;
      tail.text_end = 1'b1;
      step_results.push_back(tail);
      char_cnt = 0;
    end
    if (step_results.size() > 0) begin
      tail = step_results.pop_back();
      tail.run_last = 1'b1;
      step_results.push_back(tail);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic log_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_LOGGED) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  task automatic check_result(hed_pkg::out_item_t got);
    hed_pkg::out_item_t want;
    if (exp_results.size() == 0) begin
      log_mismatch($sformatf("result %02h/%b/%b with no request waiting",
                             got.char_out, got.run_last, got.text_end));
      return;
    end
    want = exp_results.pop_front();
    if (got.char_out !== want.char_out)
      log_mismatch($sformatf("char_out %02h, want %02h", got.char_out, want.char_out));
    if (got.run_last !== want.run_last)
      log_mismatch($sformatf("run_last %b, want %b (char %02h)",
                             got.run_last, want.run_last, want.char_out));
    if (got.text_end !== want.text_end)
      log_mismatch($sformatf("text_end %b, want %b (char %02h)",
                             got.text_end, want.text_end, want.char_out));
  endtask

  function automatic int idle_pct(idle_mode_t m, bit tx_side);
    if (m == IDLE_BOTH) return 38;
    if (tx_side && m == IDLE_TX) return 62;
    if (!tx_side && m == IDLE_RX) return 62;
    return 0;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: check on every accepted pop, then pick the next pop level.
  // A hold-off request from the stimulus side is counted down here.
  // --------------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst_n && pop && !empty) check_result(out_item);
    if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= idle_pct(idle_mode, 1'b0));
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one request, hold it until taken, predict, then maybe idle.
  task automatic send_request(logic [7:0] ch, logic last, logic typed,
                              hed_pkg::out_item_t want);
    hed_pkg::in_item_t req;
    req.char_in   = ch;
    req.text_last = last;
    in_item <= req;
    push    <= 1'b1;
    do @(posedge clk); while (full);
    predict_request(ch, last);
    if (typed) begin
      exp_results.push_back(want);
    end else begin
      foreach (step_results[i]) exp_results.push_back(step_results[i]);
    end
    phase_sent++;
    // Drop push for a random gap; otherwise the next request follows at once.
    if ($urandom_range(0, 99) < idle_pct(idle_mode, 1'b1)) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct(idle_mode, 1'b1));
    end
  endtask

  // Stop offering, wait until every expected result is in, then let the
  // decoder settle.
  task automatic wait_drained();
    push <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(int v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[hed_pkg::CNT_W-1:0];
    @(posedge clk);
    lim_reg = v;
    cfg_we <= 1'b0;
  endtask

  // Build one random text: mostly entities, partial entities and plain
  // bytes, closed by a zero byte or by the last flag. One text in ten is
  // raw noise with random zeros and last flags.
  task automatic send_text();
    logic [7:0] txt [$];
    int e;
    int cut;
    int pieces;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12))
        send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), PRED, NO_RES);
      return;
    end
    pieces = $urandom_range(1, 6);
    repeat (pieces) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          e = $urandom_range(0, 4);
          for (int k = 0; k < ENT_SIZE[e]; k++) txt.push_back(spell_at(e, k));
        end
        4, 5: begin
          // prefix of an entity, then a break byte or nothing at all
          e = $urandom_range(0, 4);
          cut = $urandom_range(1, ENT_SIZE[e] - 1);
          for (int k = 0; k < cut; k++) txt.push_back(spell_at(e, k));
          case ($urandom_range(0, 2))
            0: txt.push_back(hed_pkg::CHAR_AMP);
            1: txt.push_back(8'($urandom_range(32, 126)));
            default: ;
          endcase
        end
        6, 7: repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(32, 126)));
        8: txt.push_back(8'($urandom_range(1, 255)));
        default: txt.push_back(hed_pkg::CHAR_AMP);
      endcase
    end
    if ($urandom_range(0, 1)) begin
      foreach (txt[i]) send_request(txt[i], 1'b0, PRED, NO_RES);
      send_request(hed_pkg::CHAR_NUL, 1'($urandom_range(0, 1)), PRED, NO_RES);
    end else begin
      foreach (txt[i]) send_request(txt[i], (i == txt.size() - 1), PRED, NO_RES);
    end
  endtask

  function automatic int phase_limit(int p);
    case (p)
      0: return 0;
      1: return LIMIT_MAX;
      2: return 3;
      3: return $urandom_range(1, 10);
      5: return $urandom_range(0, LIMIT_MAX);
      6: return 1;
      default: return LIMIT_MAX;
    endcase
  endfunction

  function automatic idle_mode_t phase_mode(int p);
    case (p % 4)
      1: return IDLE_TX;
      2: return IDLE_RX;
      3: return IDLE_BOTH;
      default: return IDLE_NONE;
    endcase
  endfunction

  initial begin
    bit paused;
    paused = 1'b0;

    // Reset: the decoder comes up with an empty buffer and the full limit.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Scripted text, no idling.
    for (int i = 0; i < SCRIPT_LEN; i++)
      send_request(SCRIPT[i].ch, SCRIPT[i].last, SCRIPT[i].typed, SCRIPT[i].res);

    // Random texts, one limit setting and idling pattern per phase.
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      write_limit(phase_limit(p));
      idle_mode <= phase_mode(p);
      // Stall the result side for a long stretch so the decoder fills up
      // and pushes back on the request side.
      if (p == PRESSURE_PHASE) hold_token <= hold_token + 1;
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS) begin
        send_text();
        // Halfway through, hold new requests until everything is out.
        if (p == PRESSURE_PHASE && !paused && phase_sent >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    wait_drained();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
